// ===== hw/rtl/arrival_time_priority_queue_assert.svh =====
// Assertion macros for the arrival-time priority queue.
`ifndef ARRIVAL_TIME_PRIORITY_QUEUE_ASSERT_SVH
`define ARRIVAL_TIME_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ATPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ATPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define ATPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/atpq_pkg.sv =====
// Types and constants shared by the arrival-time priority queue.
package atpq_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 5;

    // Operation codes of an input word
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                kind;
        logic [KEY_W-1:0]    arrival_time;
        logic [HANDLE_W-1:0] track_handle;
    } t_in;

    typedef struct packed {
        logic                head_valid;
        logic [KEY_W-1:0]    head_time;
        logic [HANDLE_W-1:0] head_handle;
        logic [COUNT_W-1:0]  entry_count;
        t_status             status;
    } t_out;

    // One stored track
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    // Command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/arrival_time_priority_queue.sv =====
// Top level of the arrival-time priority queue: cell chain, count and result register.
// Usage:
//   Input channel (i_valid / o_ready / i_data) carries one word per operation:
//   add a track (kind 0, with arrival time and handle) or remove the head (kind 1).
//   Output channel (o_valid / i_ready / o_data) returns exactly one result word
//   per input word: head after the operation, entry count and status.
//   The result is registered and valid in the cycle after the input word is accepted.
//   Throughput: one word per cycle while the receiver keeps taking results; every cell
//   of the chain compares its key against the new key in parallel and shifts or holds.
//   o_ready is high while the result register is empty or being drained, so a
//   stalled receiver blocks new input only once a result is waiting.
//   An add to a full queue returns status 1 and leaves the queue unchanged;
//   a remove on an empty queue returns status 2 and all-zero head fields.
//   Equal arrival times leave in the order they were added.
//   Reset clears the entry count and the result valid flag; the queue is
//   empty and ready once reset is released.
//   entry_count reports the low 5 bits of the count.
module arrival_time_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  atpq_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output atpq_pkg::t_out  o_data
);

`include "arrival_time_priority_queue_assert.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic                 w_acc;
    logic                 w_full;
    logic                 w_empty;
    atpq_pkg::t_cell_cmd  w_cmd;
    atpq_pkg::t_slot      w_new;
    atpq_pkg::t_slot      w_slot [DEPTH];
    atpq_pkg::t_slot      w_next [DEPTH];
    logic [DEPTH-1:0]     w_keep;
    atpq_pkg::t_status    w_status;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    atpq_pkg::t_out       r_out;
    atpq_pkg::t_out       n_out;

    // Accept a word whenever the result register is free or draining
    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_new.key    = i_data.arrival_time;
    assign w_new.handle = i_data.track_handle;

    // Broadcast the operation to the chain
    assign w_cmd.ins = w_acc && (i_data.kind == atpq_pkg::KIND_ADD) && !w_full;
    assign w_cmd.pop = w_acc && (i_data.kind == atpq_pkg::KIND_REMOVE) && !w_empty;

    // Build the chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        atpq_pkg::t_slot w_prev;
        atpq_pkg::t_slot w_nbr;
        logic            w_prev_keep;

        if (g == 0) begin : g_first
            assign w_prev      = '0;
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev      = w_slot[g-1];
            assign w_prev_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_nbr = '0;
        end else begin : g_inner
            assign w_nbr = w_slot[g+1];
        end

        atpq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occ       (CW'(g) < r_count),
            .i_new       (w_new),
            .i_prev      (w_prev),
            .i_prev_keep (w_prev_keep),
            .i_next      (w_nbr),
            .o_slot      (w_slot[g]),
            .o_keep      (w_keep[g]),
            .o_next_slot (w_next[g])
        );
    end

    // Advance the count and classify the word
    always_comb begin
        n_count  = r_count;
        w_status = atpq_pkg::STAT_OK;
        priority if (w_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else if (w_acc && (i_data.kind == atpq_pkg::KIND_ADD)) begin
            w_status = atpq_pkg::STAT_FULL;
        end else if (w_acc) begin
            w_status = atpq_pkg::STAT_EMPTY;
        end else begin
            // hold the count when no word is taken
            n_count = r_count;
        end
    end

    // Form the result word from the head cell's next content
    always_comb begin
        n_out.head_valid  = (n_count != '0);
        n_out.head_time   = (n_count != '0) ? w_next[0].key : '0;
        n_out.head_handle = (n_count != '0) ? w_next[0].handle : '0;
        n_out.entry_count = atpq_pkg::COUNT_W'(n_count);
        n_out.status      = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload with each accepted word
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ATPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `ATPQ_ASSERT(a_add_grows, i_clk, i_rst_n, w_cmd.ins |=> (r_count == $past(r_count) + CW'(1)), "add did not grow count")
    `ATPQ_ASSERT(a_full_reject, i_clk, i_rst_n, (w_acc && w_full && (i_data.kind == atpq_pkg::KIND_ADD)) |=> (o_data.status == atpq_pkg::STAT_FULL && $stable(r_count)), "full add not rejected")
    `ATPQ_ASSERT(a_head_sorted, i_clk, i_rst_n, (r_count >= CW'(2)) |-> (w_slot[0].key <= w_slot[1].key), "head out of order")

endmodule

// ===== hw/rtl/atpq_cell.sv =====
// One storage cell of the sorted track chain.
module atpq_cell (
    input  logic                i_clk,
    input  atpq_pkg::t_cell_cmd i_cmd,
    input  logic                i_occ,
    input  atpq_pkg::t_slot     i_new,
    input  atpq_pkg::t_slot     i_prev,
    input  logic                i_prev_keep,
    input  atpq_pkg::t_slot     i_next,
    output atpq_pkg::t_slot     o_slot,
    output logic                o_keep,
    output atpq_pkg::t_slot     o_next_slot
);

    atpq_pkg::t_slot r_slot;
    atpq_pkg::t_slot n_slot;

    // Hold while occupied by a track that is earlier or equal to the new one
    assign o_keep = i_occ && (r_slot.key <= i_new.key);

    // Pick the next content: hold, take the new track, shift down or shift up
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_slot = r_slot;
            end else if (i_prev_keep) begin
                n_slot = i_new;
            end else begin
                n_slot = i_prev;
            end
        end else if (i_cmd.pop) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot      = r_slot;
    assign o_next_slot = n_slot;

endmodule

// ===== tb/sv/arrival_time_priority_queue_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the arrival-time priority queue: tracks the sorted store and checks each result.
module arrival_time_priority_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  atpq_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  atpq_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending
);

    atpq_pkg::t_slot track_q[$];      // held tracks, earliest first
    atpq_pkg::t_out  head_q[$];       // predicted result words not yet seen
    int              errors     = 0;
    int              result_idx = 0;

    // Apply one operation word to the shadow store and return the head it leaves
    function automatic atpq_pkg::t_out apply_word(atpq_pkg::t_in w);
        atpq_pkg::t_out  r;
        atpq_pkg::t_slot s;
        int              pos;
        r = '0;
        r.status = atpq_pkg::STAT_OK;
        if (w.kind == atpq_pkg::KIND_ADD) begin
            if (track_q.size() >= DEPTH) begin
                r.status = atpq_pkg::STAT_FULL;
            end else begin
                // new track goes behind every track with an equal or earlier time
                pos = 0;
                while (pos < track_q.size() && track_q[pos].key <= w.arrival_time) begin
                    pos++;
                end
                s.key    = w.arrival_time;
                s.handle = w.track_handle;
                track_q.insert(pos, s);
            end
        end else if (track_q.size() == 0) begin
            r.status = atpq_pkg::STAT_EMPTY;
        end else begin
            void'(track_q.pop_front());
        end
        if (track_q.size() > 0) begin
            r.head_valid  = 1'b1;
            r.head_time   = track_q[0].key;
            r.head_handle = track_q[0].handle;
        end
        r.entry_count = atpq_pkg::COUNT_W'(track_q.size());
        return r;
    endfunction

    // Compare results first, then queue the prediction for a newly accepted word
    always @(posedge i_clk) begin
        atpq_pkg::t_out want;
        logic           bad;
        if (!i_rst_n) begin
            track_q.delete();
            head_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (head_q.size() == 0) begin
                    errors++;
                    $display("%0t: result %0d: expected none, actual %p",
                             $time, result_idx, i_out_data);
                end else begin
                    want = head_q.pop_front();
                    bad  = (i_out_data.head_valid  !== want.head_valid)  ||
                           (i_out_data.head_time   !== want.head_time)   ||
                           (i_out_data.head_handle !== want.head_handle) ||
                           (i_out_data.entry_count !== want.entry_count) ||
                           (i_out_data.status      !== want.status);
                    if (bad) begin
                        errors++;
                        $display("%0t: result %0d: expected v=%0b t=%h h=%h n=%0d s=%0d",
                                 $time, result_idx, want.head_valid, want.head_time,
                                 want.head_handle, want.entry_count, want.status);
                        $display("%0t: result %0d: actual   v=%0b t=%h h=%h n=%0d s=%0d",
                                 $time, result_idx, i_out_data.head_valid,
                                 i_out_data.head_time, i_out_data.head_handle,
                                 i_out_data.entry_count, i_out_data.status);
                    end
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                head_q.insert(head_q.size(), apply_word(i_in_data));
            end
        end
        o_fail_count <= errors;
        o_pending    <= head_q.size();
    end

endmodule

// ===== tb/sv/arrival_time_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the arrival-time priority queue: clock, reset, traffic and verdict.
module arrival_time_priority_queue_tb;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 1000;
    localparam int PHASE_LEN    = 48;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    atpq_pkg::t_in  i_data  = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    atpq_pkg::t_out o_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit steady      = 1'b1;     // no gaps on either side while set

    always #4 i_clk = ~i_clk;

    arrival_time_priority_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    arrival_time_priority_queue_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic atpq_pkg::t_in make_word(logic kind,
                                                logic [atpq_pkg::KEY_W-1:0] t,
                                                logic [atpq_pkg::HANDLE_W-1:0] h);
        atpq_pkg::t_in w;
        w.kind         = kind;
        w.arrival_time = t;
        w.track_handle = h;
        return w;
    endfunction

    // Pick a random handle over the full handle range
    function automatic logic [atpq_pkg::HANDLE_W-1:0] pick_handle();
        return atpq_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Bias arrival times toward extremes and a narrow band so ties are common
    function automatic logic [atpq_pkg::KEY_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(0, 7);
            5:       return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(input atpq_pkg::t_in w);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every predicted word has come back
    task automatic wait_results();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls unless in a steady stretch
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!steady && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
        end
        i_ready <= (stall_left == 0);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   n;
        int   add_pct;
        logic kind;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Remove on an empty store, with every payload bit set
        send_word(make_word(atpq_pkg::KIND_REMOVE, '1, '1));
        // Extreme keys and handles, then ties at the head and in the middle
        send_word(make_word(atpq_pkg::KIND_ADD, '1, '1));
        send_word(make_word(atpq_pkg::KIND_ADD, '0, '0));
        send_word(make_word(atpq_pkg::KIND_ADD, '0, 16'h0001));
        send_word(make_word(atpq_pkg::KIND_ADD, 32'h8000_0000, 16'h5555));
        send_word(make_word(atpq_pkg::KIND_ADD, 32'h8000_0000, 16'hAAAA));
        // Fill the store, then add once more to a full store
        repeat (DEPTH - 5) begin
            send_word(make_word(atpq_pkg::KIND_ADD, pick_time(), pick_handle()));
        end
        send_word(make_word(atpq_pkg::KIND_ADD, '0, 16'h1234));
        // Remove with junk in the ignored fields
        send_word(make_word(atpq_pkg::KIND_REMOVE, 32'h1234_5678, 16'hBEEF));
        wait_results();

        // Random traffic in phases that push toward full, toward empty, or hover
        add_pct = 50;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_LEN == 0) begin
                case ((n / PHASE_LEN) % 3)
                    0:       add_pct = 85;
                    1:       add_pct = 15;
                    default: add_pct = 50;
                endcase
                steady = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_WORDS / 2) begin
                wait_results();
            end
            kind = ($urandom_range(0, 99) < add_pct) ? atpq_pkg::KIND_ADD
                                                     : atpq_pkg::KIND_REMOVE;
            send_word(make_word(kind, pick_time(), pick_handle()));
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
